[design/mixclip_pkg.sv]
package mixclip_pkg;

  // Queue and sample geometry
  localparam int unsigned QUEUE_DEPTH     = 4096;
  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned CLIP_TABLE_SIZE = 256;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FRAME_W = 2 * SAMPLE_BITS;

  // Gains are unsigned Q2.8
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned GAIN_FRAC  = 8;
  localparam int unsigned GAIN_MAX   = 768;
  localparam int unsigned GAIN_RESET = 256;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIC_GAIN    = 2'd0,
    CFG_SPEECH_GAIN = 2'd1,
    CFG_MIC_MUTED   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_MIX   = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } ctl_state_e;

  // Datapath widths of one lane
  localparam int unsigned PROD_W    = SAMPLE_BITS + GAIN_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned POS_SHIFT = (SAMPLE_BITS - 1) + GAIN_FRAC + 3;
  localparam int unsigned TAB_IDX_W = $clog2(CLIP_TABLE_SIZE + 1);
  localparam int unsigned NUM_W     = SUM_W + TAB_IDX_W;
  localparam int unsigned SEG_W     = NUM_W - POS_SHIFT;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned Y_W       = SAMPLE_BITS - 1;
  localparam int unsigned IPROD_W   = Y_W + FRAC_W;
  localparam int unsigned LANE_STAGES = 6;

  typedef struct packed {
    logic                          start;
    logic signed [SAMPLE_BITS-1:0] mic_sample;
    logic signed [SAMPLE_BITS-1:0] speech_sample;
    logic [GAIN_W-1:0]             mic_gain;
    logic [GAIN_W-1:0]             speech_gain;
  } lane_req_t;

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] sample;
  } lane_rsp_t;

  typedef struct packed {
    logic load;
    logic mix;
    logic dropped;
    logic period;
  } merge_req_t;

  // Clip curve, built at elaboration
  localparam logic [63:0] ONE_Q32    = 64'd1 << 32;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
  localparam logic [63:0] Y_MAX      = (64'd1 << Y_W) - 64'd1;

  typedef logic [Y_W-1:0] clip_tab_t [CLIP_TABLE_SIZE+1];

  // Restoring long division
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-y with y in Q32, result in Q32
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] y);
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos_sum;
    logic [63:0] neg_sum;
    logic [63:0] acc;
    k       = y >> 32;
    f       = {32'd0, y[31:0]};
    term    = ONE_Q32;
    pos_sum = ONE_Q32;
    neg_sum = '0;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64((term * f) >> 32, 64'(n));
      if ((n & 1) != 0) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    acc = pos_sum - neg_sum;
    for (int j = 0; j < 16; j++) begin
      if (64'(j) < k) begin
        acc = (acc * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
      end
    end
    return acc;
  endfunction

  function automatic clip_tab_t build_clip_tab();
    clip_tab_t   tab;
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] t;
    for (int i = 0; i <= CLIP_TABLE_SIZE; i++) begin
      y   = (64'(i) << 36) / CLIP_TABLE_SIZE;
      e   = exp_neg_q32(y);
      den = ONE_Q32 + e;
      num = ((ONE_Q32 - e) << (SAMPLE_BITS - 1)) + (den >> 1);
      t   = udiv64(num, den);
      if (t > Y_MAX) begin
        t = Y_MAX;
      end
      tab[i] = t[Y_W-1:0];
    end
    return tab;
  endfunction

  localparam clip_tab_t CLIP_TAB = build_clip_tab();

endpackage

[design/mixclip_in_if.sv]
interface mixclip_in_if import mixclip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic signed [SAMPLE_BITS-1:0] mic_left;
  logic signed [SAMPLE_BITS-1:0] mic_right;
  logic                          mic_present;
  logic signed [SAMPLE_BITS-1:0] speech_left;
  logic signed [SAMPLE_BITS-1:0] speech_right;
  logic                          period_end;

  modport source (
    output valid, kind, mic_left, mic_right, mic_present, speech_left, speech_right,
           period_end,
    input  ready
  );

  modport sink (
    input  valid, kind, mic_left, mic_right, mic_present, speech_left, speech_right,
           period_end,
    output ready
  );
endinterface

[design/mixclip_out_if.sv]
interface mixclip_out_if import mixclip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          push_dropped;
  logic                          period_last;

  modport source (
    output valid, out_left, out_right, push_dropped, period_last,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right, push_dropped, period_last,
    output ready
  );
endinterface

[design/mixclip_ram.sv]
module mixclip_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mixclip_lane.sv]
module mixclip_lane import mixclip_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_req_t req_i,
  output lane_rsp_t rsp_o
);

  logic [LANE_STAGES-1:0] vld_q;

  logic signed [PROD_W-1:0] pm_q, ps_q;
  logic signed [PROD_W-1:0] pm_d, ps_d;
  logic signed [GAIN_W:0]   mg_s, sg_s;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         mag_q;
  logic                     neg2_q, neg3_q, neg4_q;
  logic [Y_W-1:0]           t0_q, t0_4_q, d_q;
  logic [FRAC_W-1:0]        frac_q;
  logic [IPROD_W-1:0]       iprod_q;
  logic signed [SAMPLE_BITS-1:0] res_q;

  logic [NUM_W-1:0]     num;
  logic [SEG_W-1:0]     seg;
  logic                 sat;
  logic [TAB_IDX_W-1:0] lo_idx, hi_idx;
  logic [IPROD_W:0]     rnd;
  logic [Y_W-1:0]       y;

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_STAGES-2:0], req_i.start};
    end
  end

  // Stage 0: scale both sources
  assign mg_s = {1'b0, req_i.mic_gain};
  assign sg_s = {1'b0, req_i.speech_gain};
  assign pm_d = PROD_W'(req_i.mic_sample) * PROD_W'(mg_s);
  assign ps_d = PROD_W'(req_i.speech_sample) * PROD_W'(sg_s);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      pm_q <= pm_d;
      ps_q <= ps_d;
    end
  end

  // Stage 1: sum the terms
  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      sum_q <= SUM_W'(pm_q) + SUM_W'(ps_q);
    end
  end

  // Stage 2: split into sign and magnitude
  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      neg2_q <= sum_q[SUM_W-1];
      mag_q  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    end
  end

  // Stage 3: locate the curve segment and fetch its end points
  assign num    = NUM_W'(mag_q) * NUM_W'(CLIP_TABLE_SIZE);
  assign seg    = num[NUM_W-1:POS_SHIFT];
  assign sat    = seg >= SEG_W'(CLIP_TABLE_SIZE);
  assign lo_idx = sat ? TAB_IDX_W'(CLIP_TABLE_SIZE - 1) : seg[TAB_IDX_W-1:0];
  assign hi_idx = lo_idx + TAB_IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      neg3_q <= neg2_q;
      if (sat) begin
        t0_q   <= CLIP_TAB[CLIP_TABLE_SIZE];
        d_q    <= '0;
        frac_q <= '0;
      end else begin
        t0_q   <= CLIP_TAB[lo_idx];
        d_q    <= CLIP_TAB[hi_idx] - CLIP_TAB[lo_idx];
        frac_q <= num[POS_SHIFT-1 -: FRAC_W];
      end
    end
  end

  // Stage 4: scale the step by the fraction
  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      neg4_q  <= neg3_q;
      t0_4_q  <= t0_q;
      iprod_q <= IPROD_W'(d_q) * IPROD_W'(frac_q);
    end
  end

  // Stage 5: round, add and restore the sign
  assign rnd = (IPROD_W + 1)'(iprod_q) + (IPROD_W + 1)'(1 << (FRAC_W - 1));
  assign y   = t0_4_q + rnd[FRAC_W +: Y_W];

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      res_q <= neg4_q ? -$signed(SAMPLE_BITS'(y)) : $signed(SAMPLE_BITS'(y));
    end
  end

  assign rsp_o.done   = vld_q[LANE_STAGES-1];
  assign rsp_o.sample = res_q;

endmodule

[design/mixclip_merge.sv]
module mixclip_merge import mixclip_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  merge_req_t                    req_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  output logic                          free_o,
  mixclip_out_if.source                 out_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          dropped_q, period_q;

  assign free_o = !valid_q || out_o.ready;

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Combine lane results with the item flags
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      left_q    <= req_i.mix ? left_i : '0;
      right_q   <= req_i.mix ? right_i : '0;
      dropped_q <= req_i.dropped;
      period_q  <= req_i.period;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_left     = left_q;
  assign out_o.out_right    = right_q;
  assign out_o.push_dropped = dropped_q;
  assign out_o.period_last  = period_q;

endmodule

[design/stereo_two_source_mixer_soft_clip_top.sv]
// Stereo mixer: microphone frame plus queued speech frame, tanh soft clip.
// Input channel in_i carries one item per beat: kind selects mix, speech push
// or queue flush (the fourth code does nothing but still yields a result).
// Output channel out_o returns exactly one result beat for every input beat.
// Gains and mute are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, which the block does not enforce.
// A write takes effect at the next clock edge. One item at a time: a mix item has
// its speech frame read from the queue as it is accepted, then it runs through the
// six-stage clip pipeline that runs in both channel lanes side by side. Push, flush
// and the no-op code skip the lanes. The result beat is loaded into the output
// register once the last pipeline stage is done and that register is free.
// Reset clears the queue pointers and fill count and restores the gains to
// 1.0 and mute off; the queue memory itself is not cleared and needs no pass.
// When the receiver stalls, the finished beat waits in the output register;
// one more item is accepted and worked on, then it waits for that register.
module stereo_two_source_mixer_soft_clip_top import mixclip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i,
  mixclip_in_if.sink           in_i,
  mixclip_out_if.source        out_o
);

  ctl_state_e state_q, state_d;

  logic [GAIN_W-1:0] mic_gain_q, speech_gain_q;
  logic              mic_muted_q;

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  logic                          accept, is_mix, is_push, is_flush;
  logic                          full, empty, push_ok, pop;
  logic [FRAME_W-1:0]            rdata;
  logic signed [SAMPLE_BITS-1:0] mic_l_q, mic_r_q;
  logic [GAIN_W-1:0]             mg_q, sg_q;
  logic                          sp_avail_q, mix_q, drop_q, period_q;

  lane_req_t  lreq_l, lreq_r;
  lane_rsp_t  lrsp_l, lrsp_r;
  merge_req_t mreq;
  logic       merge_free;
  logic       lanes_done;

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : g;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_gain_q    <= GAIN_W'(GAIN_RESET);
      speech_gain_q <= GAIN_W'(GAIN_RESET);
      mic_muted_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIC_GAIN:    mic_gain_q    <= cfg_wdata_i;
        CFG_SPEECH_GAIN: speech_gain_q <= cfg_wdata_i;
        CFG_MIC_MUTED:   mic_muted_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Decode the item kind
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    is_mix   = 1'b0;
    is_push  = 1'b0;
    is_flush = 1'b0;
    unique case (kind_e'(in_i.kind))
      KIND_MIX:   is_mix   = 1'b1;
      KIND_PUSH:  is_push  = 1'b1;
      KIND_FLUSH: is_flush = 1'b1;
      default: ;
    endcase
  end

  // Queue bookkeeping
  assign full    = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill_q == '0);
  assign push_ok = accept && is_push && !full;
  assign pop     = accept && is_mix && !empty;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    priority if (accept && is_flush) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end else if (push_ok) begin
      wr_ptr_d = next_ptr(wr_ptr_q);
      fill_d   = fill_q + CNT_W'(1);
    end else if (pop) begin
      rd_ptr_d = next_ptr(rd_ptr_q);
      fill_d   = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  mixclip_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i ({in_i.speech_right, in_i.speech_left}),
    .re_i    (accept && is_mix),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mic_l_q    <= in_i.mic_left;
      mic_r_q    <= in_i.mic_right;
      mg_q       <= (mic_muted_q || !in_i.mic_present) ? '0 : clamp_gain(mic_gain_q);
      sg_q       <= clamp_gain(speech_gain_q);
      sp_avail_q <= !empty;
      mix_q      <= is_mix;
      drop_q     <= is_push && full;
      period_q   <= in_i.period_end;
    end
  end

  // Channel lanes
  always_comb begin
    lreq_l.start         = (state_q == ST_START);
    lreq_l.mic_sample    = mic_l_q;
    lreq_l.speech_sample = sp_avail_q ? $signed(rdata[SAMPLE_BITS-1:0]) : '0;
    lreq_l.mic_gain      = mg_q;
    lreq_l.speech_gain   = sg_q;
    lreq_r.start         = (state_q == ST_START);
    lreq_r.mic_sample    = mic_r_q;
    lreq_r.speech_sample = sp_avail_q ? $signed(rdata[FRAME_W-1:SAMPLE_BITS]) : '0;
    lreq_r.mic_gain      = mg_q;
    lreq_r.speech_gain   = sg_q;
  end

  mixclip_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq_l),
    .rsp_o  (lrsp_l)
  );

  mixclip_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq_r),
    .rsp_o  (lrsp_r)
  );

  assign lanes_done = lrsp_l.done && lrsp_r.done;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    mreq.load    = 1'b0;
    mreq.mix     = mix_q;
    mreq.dropped = drop_q;
    mreq.period  = period_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_mix ? ST_START : ST_DONE;
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (lanes_done) begin
          if (merge_free) begin
            mreq.load = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (merge_free) begin
          mreq.load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  mixclip_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .left_i  (lrsp_l.sample),
    .right_i (lrsp_r.sample),
    .free_o  (merge_free),
    .out_o   (out_o)
  );

endmodule

[tb/stereo_two_source_mixer_soft_clip_top_test.sv]
`timescale 1ns / 1ps

module stereo_two_source_mixer_soft_clip_top_test;
  import mixclip_pkg::*;

  localparam logic [1:0]           KIND_NOP    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned          SEG_SHIFT   = SAMPLE_BITS + 10;
  localparam logic [63:0]          Q32_ONE     = 64'd1 << 32;
  localparam logic [63:0]          INV_E_Q32   = 64'd1580030169;
  localparam longint               PEAK        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam int unsigned          CYCLE_LIMIT = 1_000_000;
  localparam int unsigned          HOLD_CYCLES = 400;
  localparam int unsigned          PHASE_ITEMS = 230;
  localparam int unsigned          MAX_SHOWN   = 10;
  localparam int unsigned          IDLE_PCT    = 24;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    dropped;
    logic    last;
  } mix_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    sample_t     mic_l;
    sample_t     mic_r;
    logic        mic_on;
    sample_t     sp_l;
    sample_t     sp_r;
    logic        period;
    logic        typed;
    mix_result_t want;
  } mix_item_t;

  localparam sample_t     S_MAX    = 24'sh7FFFFF;
  localparam sample_t     S_MIN    = 24'sh800000;
  localparam mix_result_t ZERO_RES = '0;
  localparam mix_result_t LAST_RES = '{left: '0, right: '0, dropped: 1'b0, last: 1'b1};

  // Directed beats at reset gains; typed rows carry their result, others use the predictor
  localparam int unsigned DIR_ROWS = 24;
  localparam mix_item_t DIRECTED [DIR_ROWS] = '{
    '{KIND_NOP,   S_MAX,         S_MIN,         1'b1, S_MAX,         S_MIN,
      1'b1, 1'b1, LAST_RES},
    '{KIND_MIX,   S_MAX,         S_MAX,         1'b0, 24'sd0,        24'sd0,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_MIX,   S_MAX,         S_MIN,         1'b1, 24'sd0,        24'sd0,
      1'b1, 1'b0, ZERO_RES},
    '{KIND_MIX,   S_MIN,         S_MAX,         1'b1, S_MAX,         S_MAX,
      1'b0, 1'b0, ZERO_RES},
    '{KIND_MIX,   24'sd0,        24'sd0,        1'b1, S_MIN,         S_MIN,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_MIX,   24'shFFFFFF,   24'sd1,        1'b1, 24'sd0,        24'sd0,
      1'b1, 1'b0, ZERO_RES},
    '{KIND_MIX,   24'sh400000,   24'shC00000,   1'b1, 24'sd0,        24'sd0,
      1'b0, 1'b0, ZERO_RES},
    '{KIND_PUSH,  24'sd0,        24'sd0,        1'b0, S_MAX,         S_MIN,
      1'b1, 1'b1, LAST_RES},
    '{KIND_PUSH,  S_MAX,         S_MAX,         1'b1, S_MIN,         S_MAX,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_PUSH,  S_MIN,         S_MIN,         1'b1, 24'sd1,        24'shFFFFFF,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_PUSH,  24'sd0,        24'sd0,        1'b0, 24'sd0,        24'sd0,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_MIX,   S_MAX,         S_MIN,         1'b1, 24'sh5A5A5A,   24'shA5A5A5,
      1'b0, 1'b0, ZERO_RES},
    '{KIND_MIX,   S_MIN,         S_MAX,         1'b0, 24'sd0,        24'sd0,
      1'b1, 1'b0, ZERO_RES},
    '{KIND_MIX,   S_MIN,         S_MIN,         1'b1, 24'sd0,        24'sd0,
      1'b0, 1'b0, ZERO_RES},
    '{KIND_MIX,   24'sd0,        24'sd0,        1'b1, S_MAX,         S_MAX,
      1'b1, 1'b1, LAST_RES},
    '{KIND_MIX,   S_MAX,         S_MAX,         1'b1, 24'sd0,        24'sd0,
      1'b0, 1'b0, ZERO_RES},
    '{KIND_PUSH,  24'sd0,        24'sd0,        1'b0, 24'sh123456,   24'shF54322,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_PUSH,  24'sd0,        24'sd0,        1'b0, 24'sh7FFF00,   24'sh000100,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_FLUSH, S_MAX,         S_MIN,         1'b1, S_MAX,         S_MIN,
      1'b1, 1'b1, LAST_RES},
    '{KIND_MIX,   S_MAX,         S_MIN,         1'b0, 24'sd0,        24'sd0,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_FLUSH, 24'sd0,        24'sd0,        1'b0, 24'sd0,        24'sd0,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_PUSH,  24'sd0,        24'sd0,        1'b0, 24'sd1,        24'shFFFFFF,
      1'b0, 1'b1, ZERO_RES},
    '{KIND_MIX,   24'sd1,        24'shFFFFFF,   1'b1, 24'sd0,        24'sd0,
      1'b1, 1'b0, ZERO_RES},
    '{KIND_NOP,   24'sd0,        24'sd0,        1'b0, 24'sd0,        24'sd0,
      1'b0, 1'b1, ZERO_RES}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [GAIN_W-1:0]    cfg_wdata_i;

  mixclip_in_if  in_bus ();
  mixclip_out_if out_bus ();

  stereo_two_source_mixer_soft_clip_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Predictor state: shadow registers, speech queue, clip curve
  logic [GAIN_W-1:0]          mic_gain_q;
  logic [GAIN_W-1:0]          speech_gain_q;
  logic                       mic_mute_q;
  logic [2*SAMPLE_BITS-1:0]   speech_fifo [$];
  longint                     tanh_pts [CLIP_TABLE_SIZE+1];
  mix_result_t                pending_results [$];

  mix_item_t   offered;
  mix_result_t predicted;
  mix_result_t observed;
  bit          steady;
  bit          hold_req;
  bit          hold_done;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned mix_count, fed_count, push_count, drop_count, flush_count, nop_count;
  int unsigned setting_count, peak_depth;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // e^-x for x in Q32, result in Q32
  function automatic logic [63:0] falloff_q32(input logic [63:0] x);
    logic [63:0] whole, part, term, plus, minus, acc;
    whole = x >> 32;
    part  = x & 64'hFFFF_FFFF;
    term  = Q32_ONE;
    plus  = Q32_ONE;
    minus = '0;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * part) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    acc = plus - minus;
    repeat (int'(whole)) acc = (acc * INV_E_Q32 + (64'd1 << 31)) >> 32;
    return acc;
  endfunction

  // Curve point i: tanh(8i/N) in Q1.(SAMPLE_BITS-1)
  function automatic longint tanh_point(input int i);
    logic [63:0] x2, e, den, num, t;
    x2  = (64'(i) << 36) / CLIP_TABLE_SIZE;
    e   = falloff_q32(x2);
    den = Q32_ONE + e;
    num = ((Q32_ONE - e) << (SAMPLE_BITS - 1)) + den / 2;
    t   = num / den;
    if (t > 64'(PEAK)) begin
      t = 64'(PEAK);
    end
    return longint'(t);
  endfunction

  // Interpolate the odd-symmetric curve at a sum with SAMPLE_BITS+7 fraction bits
  function automatic sample_t curve_limit(input longint s);
    logic [63:0] mag, num, idx, frac, step;
    longint      y;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    num = mag * CLIP_TABLE_SIZE;
    idx = num >> SEG_SHIFT;
    if (idx >= CLIP_TABLE_SIZE) begin
      y = tanh_pts[CLIP_TABLE_SIZE];
    end else begin
      frac = (num >> (SEG_SHIFT - 16)) & 64'hFFFF;
      step = 64'(tanh_pts[int'(idx) + 1] - tanh_pts[int'(idx)]);
      y    = tanh_pts[int'(idx)] + longint'((step * frac + 64'h8000) >> 16);
    end
    if (y > PEAK) begin
      y = PEAK;
    end
    return (s < 0) ? sample_t'(-y) : sample_t'(y);
  endfunction

  // Advance the predictor by one beat and return its result
  function automatic mix_result_t mix_step(input mix_item_t it);
    mix_result_t              res;
    longint                   sum_l, sum_r, mg, sg;
    logic [2*SAMPLE_BITS-1:0] frame;
    res      = '0;
    res.last = it.period;
    case (it.kind)
      KIND_MIX: begin
        sum_l = 0;
        sum_r = 0;
        mg    = longint'(mic_gain_q);
        sg    = longint'(speech_gain_q);
        if (mg > longint'(GAIN_MAX)) mg = longint'(GAIN_MAX);
        if (sg > longint'(GAIN_MAX)) sg = longint'(GAIN_MAX);
        if (!mic_mute_q && it.mic_on) begin
          sum_l += longint'($signed(it.mic_l)) * mg;
          sum_r += longint'($signed(it.mic_r)) * mg;
        end
        if (speech_fifo.size() != 0) begin
          frame  = speech_fifo.pop_front();
          sum_l += longint'($signed(frame[SAMPLE_BITS-1:0])) * sg;
          sum_r += longint'($signed(frame[2*SAMPLE_BITS-1:SAMPLE_BITS])) * sg;
          fed_count++;
        end
        res.left  = curve_limit(sum_l);
        res.right = curve_limit(sum_r);
        mix_count++;
      end
      KIND_PUSH: begin
        push_count++;
        if (speech_fifo.size() >= QUEUE_DEPTH) begin
          res.dropped = 1'b1;
          drop_count++;
        end else begin
          speech_fifo.push_back({it.sp_r, it.sp_l});
          if (speech_fifo.size() > peak_depth) peak_depth = speech_fifo.size();
        end
      end
      KIND_FLUSH: begin
        speech_fifo.delete();
        flush_count++;
      end
      default: begin
        nop_count++;
      end
    endcase
    return res;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Draw a beat: mix_pct percent mixes, push_pct pushes, then flushes and idle codes
  function automatic mix_item_t random_item(input int mix_pct, input int push_pct);
    mix_item_t it;
    int        r;
    it = '0;
    r  = $urandom_range(0, 99);
    if (r < mix_pct) begin
      it.kind = KIND_MIX;
    end else if (r < mix_pct + push_pct) begin
      it.kind = KIND_PUSH;
    end else if (r < 97) begin
      it.kind = KIND_FLUSH;
    end else begin
      it.kind = KIND_NOP;
    end
    it.mic_l  = random_sample();
    it.mic_r  = random_sample();
    it.mic_on = ($urandom_range(0, 3) != 0);
    it.sp_l   = random_sample();
    it.sp_r   = random_sample();
    it.period = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic note_mismatch(input string what, input mix_result_t want,
                               input mix_result_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $write("Mismatch (%s) at cycle %0d: want L=%0d R=%0d drop=%0b last=%0b, ",
             what, cycle_count, want.left, want.right, want.dropped, want.last);
      $display("got L=%0d R=%0d drop=%0b last=%0b",
               got.left, got.right, got.dropped, got.last);
    end
  endtask

  // Check result beats first, then log the accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        observed = '{left: out_bus.out_left, right: out_bus.out_right,
                     dropped: out_bus.push_dropped, last: out_bus.period_last};
        if (pending_results.size() == 0) begin
          note_mismatch("no beat expected", '0, observed);
        end else begin
          predicted = pending_results.pop_front();
          if (observed.left !== predicted.left || observed.right !== predicted.right ||
              observed.dropped !== predicted.dropped || observed.last !== predicted.last) begin
            note_mismatch("field", predicted, observed);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        predicted = mix_step(offered);
        if (offered.typed) predicted = offered.want;
        pending_results.push_back(predicted);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic offer_beat(input mix_item_t it);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= it.kind;
    in_bus.mic_left     <= it.mic_l;
    in_bus.mic_right    <= it.mic_r;
    in_bus.mic_present  <= it.mic_on;
    in_bus.speech_left  <= it.sp_l;
    in_bus.speech_right <= it.sp_r;
    in_bus.period_end   <= it.period;
    offered = it;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every result is back and the pipe has drained
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Write all registers, then a stray write to the unused index
  task automatic write_regs(input logic [GAIN_W-1:0] mic, input logic [GAIN_W-1:0] speech,
                            input logic [GAIN_W-1:0] mute);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIC_GAIN;
    cfg_wdata_i <= mic;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SPEECH_GAIN;
    cfg_wdata_i <= speech;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MIC_MUTED;
    cfg_wdata_i <= mute;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= GAIN_W'($urandom);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mic_gain_q    = mic;
    speech_gain_q = speech;
    mic_mute_q    = mute[0];
    setting_count++;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.kind         = '0;
    in_bus.mic_left     = '0;
    in_bus.mic_right    = '0;
    in_bus.mic_present  = 1'b0;
    in_bus.speech_left  = '0;
    in_bus.speech_right = '0;
    in_bus.period_end   = 1'b0;
    mic_gain_q          = GAIN_W'(GAIN_RESET);
    speech_gain_q       = GAIN_W'(GAIN_RESET);
    mic_mute_q          = 1'b0;
    setting_count       = 1;
    for (int i = 0; i <= CLIP_TABLE_SIZE; i++) tanh_pts[i] = tanh_point(i);

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at reset settings
    foreach (DIRECTED[i]) offer_beat(DIRECTED[i]);
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      steady = (p == 0);
      case (p)
        0:       write_regs(10'd768, 10'd768, 10'd0);
        1:       write_regs(10'd0, 10'd0, 10'h3FF);
        2:       write_regs(10'h3FF, 10'h3FF, 10'h002);
        3:       write_regs(10'($urandom), 10'($urandom), 10'($urandom));
        default: write_regs(10'd1, 10'd769, 10'd0);
      endcase
      repeat (PHASE_ITEMS) offer_beat(random_item(48, 42));
      settle();
    end
    steady = 1'b0;

    // Queue speech behind a stalled receiver, then drain it with mixes
    write_regs(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 10'd0);
    hold_req = 1'b1;
    repeat (30) offer_beat(random_item(0, 100));
    repeat (3) offer_beat(random_item(100, 0));
    repeat (4) offer_beat(random_item(0, 100));
    repeat (36) offer_beat(random_item(100, 0));
    repeat (20) offer_beat(random_item(48, 42));
    settle();

    $write("Covered %0d mixes (%0d with queued speech), %0d pushes (%0d dropped), ",
           mix_count, fed_count, push_count, drop_count);
    $display("%0d flushes, %0d idle codes", flush_count, nop_count);
    $write("Register settings: %0d; deepest queue %0d frames; ", setting_count, peak_depth);
    $display("one %0d-cycle output hold; %0d mismatches", HOLD_CYCLES, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
